// ===== rtl/pts_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pts_pkg: shared types and constants for the periodic task scheduler
// Table size, operation and status codes, sequencer states and the
// command bundle that the sequencer drives into the task table.
// ----------------------------------------------------------------------------
package pts_pkg;

  // Table geometry
  localparam int TASK_SLOTS = 16;
  localparam int SLOT_W     = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;

  // Field widths
  localparam int OP_W     = 2;
  localparam int ID_W     = 4;
  localparam int CNT_W    = 16;
  localparam int STAT_W   = 3;
  localparam int DIV_W    = 8;

  localparam logic [DIV_W-1:0] DIVIDE_RESET = 8'd50;

  // Operation codes
  typedef enum logic [OP_W-1:0] {
    OP_ADD      = 2'd0,
    OP_TICK     = 2'd1,
    OP_DISPATCH = 2'd2
  } op_t;

  // Result status codes
  typedef enum logic [STAT_W-1:0] {
    STAT_ADD_OK  = 3'd0,
    STAT_ADD_REJ = 3'd1,
    STAT_TICK    = 3'd2,
    STAT_READY   = 3'd3,
    STAT_NONE    = 3'd4
  } status_t;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RD,
    ST_WR,
    ST_DISP
  } state_t;

  // Sequencer to table command
  typedef struct packed {
    logic              add;
    logic              step;
    logic [SLOT_W-1:0] addr;
    logic [CNT_W-1:0]  delay;
    logic [CNT_W-1:0]  ivl;
  } table_cmd_t;

endpackage

// ===== rtl/pts_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pts_table: countdown and reload storage with the shared step unit
// Two small memories with one address port and registered read data. The
// single decrement / zero-test unit serves every entry during a table step.
// ----------------------------------------------------------------------------
module pts_table
  import pts_pkg::*;
(
  input  logic       clk,
  input  table_cmd_t cmd,
  output logic       cd_zero
);

  logic [CNT_W-1:0] cd_mem [TASK_SLOTS];
  logic [CNT_W-1:0] rl_mem [TASK_SLOTS];
  logic [CNT_W-1:0] cd_rd_r;
  logic [CNT_W-1:0] rl_rd_r;
  logic [CNT_W-1:0] cd_step;

  // Shared step unit: reload on zero, otherwise count down
  assign cd_zero = (cd_rd_r == '0);
  assign cd_step = cd_zero ? rl_rd_r : (cd_rd_r - CNT_W'(1));

  // Memory write and registered read
  always_ff @(posedge clk) begin
    if (cmd.add) begin
      cd_mem[cmd.addr] <= cmd.delay;
      rl_mem[cmd.addr] <= cmd.ivl;
    end else if (cmd.step) begin
      cd_mem[cmd.addr] <= cd_step;
    end
    cd_rd_r <= cd_mem[cmd.addr];
    rl_rd_r <= rl_mem[cmd.addr];
  end

endmodule

// ===== rtl/pts_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pts_seq: scheduler sequencer
// Decodes items, runs the prescaler, walks the table for steps and
// dispatches, keeps used and ready flags, and holds the result register.
// ----------------------------------------------------------------------------
module pts_seq
  import pts_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic [DIV_W-1:0]  tick_divide,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [OP_W-1:0]   in_operation,
  input  logic [ID_W-1:0]   in_task_id,
  input  logic [CNT_W-1:0]  in_start_delay,
  input  logic [CNT_W-1:0]  in_interval,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [STAT_W-1:0] out_status,
  output logic [ID_W-1:0]   out_ready_id,
  output logic              out_last,
  output table_cmd_t        cmd,
  input  logic              cd_zero
);

  localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(TASK_SLOTS - 1);

  state_t                  state_r, state_nxt;
  logic [SLOT_W-1:0]       idx_r, idx_nxt;
  logic [DIV_W-1:0]        prescale_r, prescale_nxt;
  logic [TASK_SLOTS-1:0]   used_r, used_nxt;
  logic [TASK_SLOTS-1:0]   ready_r, ready_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0]       out_status_r, out_status_nxt;
  logic [ID_W-1:0]         out_ready_id_r, out_ready_id_nxt;
  logic                    out_last_r, out_last_nxt;

  logic [TASK_SLOTS-1:0]   pend;
  logic [TASK_SLOTS-1:0]   below_mask;
  logic                    any_below;
  logic                    out_free;
  logic                    id_ok;
  logic [DIV_W-1:0]        pre_inc;
  logic [SLOT_W-1:0]       in_slot;

  assign pend       = used_r & ready_r;
  assign below_mask = (TASK_SLOTS'(1) << idx_r) - TASK_SLOTS'(1);
  assign any_below  = |(pend & below_mask);
  assign out_free   = !out_valid_r || out_ready;
  assign id_ok      = (32'(in_task_id) < 32'(TASK_SLOTS));
  assign pre_inc    = prescale_r + DIV_W'(1);
  assign in_slot    = SLOT_W'(in_task_id);

  assign in_ready     = (state_r == ST_IDLE) && !out_valid_r;
  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_ready_id = out_ready_id_r;
  assign out_last     = out_last_r;

  // Next state, flags, table command and result register load
  always_comb begin
    state_nxt        = state_r;
    idx_nxt          = idx_r;
    prescale_nxt     = prescale_r;
    used_nxt         = used_r;
    ready_nxt        = ready_r;
    out_valid_nxt    = out_valid_r && !out_ready;
    out_status_nxt   = out_status_r;
    out_ready_id_nxt = out_ready_id_r;
    out_last_nxt     = out_last_r;
    cmd              = '0;
    cmd.addr         = idx_r;
    cmd.delay        = in_start_delay;
    cmd.ivl          = in_interval;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && in_ready) begin
          out_ready_id_nxt = '0;
          out_last_nxt     = 1'b1;
          unique case (in_operation)
            OP_ADD: begin
              out_valid_nxt = 1'b1;
              if (id_ok) begin
                cmd.add             = 1'b1;
                cmd.addr            = in_slot;
                used_nxt[in_slot]   = 1'b1;
                ready_nxt[in_slot]  = 1'b0;
                out_status_nxt      = STAT_ADD_OK;
              end else begin
                out_status_nxt      = STAT_ADD_REJ;
              end
            end
            OP_TICK: begin
              if (pre_inc >= tick_divide) begin
                prescale_nxt = '0;
                idx_nxt      = LAST_IDX;
                state_nxt    = ST_RD;
              end else begin
                prescale_nxt   = pre_inc;
                out_valid_nxt  = 1'b1;
                out_status_nxt = STAT_TICK;
              end
            end
            OP_DISPATCH: begin
              if (pend == '0) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = STAT_NONE;
              end else begin
                idx_nxt   = LAST_IDX;
                state_nxt = ST_DISP;
              end
            end
            default: ;
          endcase
        end
      end

      // Read phase: table registers countdown and reload of idx_r
      ST_RD: begin
        state_nxt = ST_WR;
      end

      // Write phase: step a used entry through the shared unit
      ST_WR: begin
        cmd.step = used_r[idx_r];
        if (used_r[idx_r] && cd_zero) begin
          ready_nxt[idx_r] = 1'b1;
        end
        if (idx_r == '0) begin
          out_valid_nxt    = 1'b1;
          out_status_nxt   = STAT_TICK;
          out_ready_id_nxt = '0;
          out_last_nxt     = 1'b1;
          state_nxt        = ST_IDLE;
        end else begin
          idx_nxt   = idx_r - SLOT_W'(1);
          state_nxt = ST_RD;
        end
      end

      // Dispatch walk, highest index first
      ST_DISP: begin
        if (pend[idx_r]) begin
          if (out_free) begin
            out_valid_nxt    = 1'b1;
            out_status_nxt   = STAT_READY;
            out_ready_id_nxt = ID_W'(idx_r);
            out_last_nxt     = !any_below;
            ready_nxt[idx_r] = 1'b0;
            if (any_below) begin
              idx_nxt = idx_r - SLOT_W'(1);
            end else begin
              state_nxt = ST_IDLE;
            end
          end
        end else begin
          idx_nxt = idx_r - SLOT_W'(1);
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      prescale_r  <= '0;
      used_r      <= '0;
      ready_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      prescale_r  <= prescale_nxt;
      used_r      <= used_nxt;
      ready_r     <= ready_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    out_status_r   <= out_status_nxt;
    out_ready_id_r <= out_ready_id_nxt;
    out_last_r     <= out_last_nxt;
  end

endmodule

// ===== rtl/periodic_task_scheduler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// periodic_task_scheduler: time-triggered table of periodic tasks
// Prescaled base ticks step a table of countdowns; dispatch reports the
// ready task ids from the highest index down.
//
//   channel | ports                                             | handshake
//   --------+---------------------------------------------------+-----------
//   input   | in_operation, in_task_id, in_start_delay, in_int. | valid/ready
//   result  | out_status, out_ready_id, out_last                | valid/ready
//   config  | cfg_wr_data (tick_divide)                          | cfg_wr_en
//
// Add, a prescaler-only tick and an empty dispatch load the result register
// straight from the idle state. A tick that steps the table walks every entry
// from the highest index down through a read state and a write state on the
// single port, with one shared decrement unit. Dispatch walks the entries
// from the top down to the lowest ready entry; a held result stalls the walk.
// Reset is synchronous, active low, and clears flags and prescaler at once; no
// item is taken while a result waits in the output register.
// ----------------------------------------------------------------------------
module periodic_task_scheduler
  import pts_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [DIV_W-1:0]  cfg_wr_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [OP_W-1:0]   in_operation,
  input  logic [ID_W-1:0]   in_task_id,
  input  logic [CNT_W-1:0]  in_start_delay,
  input  logic [CNT_W-1:0]  in_interval,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [STAT_W-1:0] out_status,
  output logic [ID_W-1:0]   out_ready_id,
  output logic              out_last
);

  logic [DIV_W-1:0] tick_divide_r;
  table_cmd_t       cmd;
  logic             cd_zero;

  // Prescaler divide register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_divide_r <= DIVIDE_RESET;
    end else if (cfg_wr_en) begin
      tick_divide_r <= cfg_wr_data;
    end
  end

  pts_seq u_seq (
    .clk            (clk),
    .rst_n          (rst_n),
    .tick_divide    (tick_divide_r),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_operation   (in_operation),
    .in_task_id     (in_task_id),
    .in_start_delay (in_start_delay),
    .in_interval    (in_interval),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_ready_id   (out_ready_id),
    .out_last       (out_last),
    .cmd            (cmd),
    .cd_zero        (cd_zero)
  );

  pts_table u_table (
    .clk     (clk),
    .cmd     (cmd),
    .cd_zero (cd_zero)
  );

endmodule
